// ===== hw/rtl/vt4_pkg.sv =====
package vt4_pkg;

    localparam int EW          = 16;
    localparam int FB          = 8;
    localparam int IO_W        = 16;
    localparam int DIM         = 4;
    localparam int DIM_IDX_W   = $clog2(DIM);
    localparam int COL_W       = DIM * EW;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 3;
    localparam int NUM_STAGES  = 4;
    localparam int PROD_W      = 2 * EW;
    localparam int SUM_W       = PROD_W + DIM_IDX_W;

    typedef logic signed [EW-1:0]     t_elem;
    typedef logic signed [IO_W-1:0]   t_io;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic [COL_W-1:0]         t_col;

    typedef t_elem t_elem_row [DIM];
    typedef t_elem_row t_mat [DIM];

    localparam t_elem ELEM_MAX = {1'b0, {(EW-1){1'b1}}};
    localparam t_elem ELEM_MIN = {1'b1, {(EW-1){1'b0}}};
    localparam t_elem ELEM_ONE = t_elem'(64'(1) << FB);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_COLUMN_ZERO     = 3'd0,
        REG_COLUMN_ONE      = 3'd1,
        REG_COLUMN_TWO      = 3'd2,
        REG_COLUMN_THREE    = 3'd3,
        REG_ROW_VECTOR_MODE = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
        logic [NUM_STAGES-1:0] vld;
    } t_pipe_ctl;

endpackage

// ===== hw/rtl/vt4_if.sv =====
interface vt4_vec_if;
    import vt4_pkg::*;

    logic valid;
    logic ready;
    t_io  vec_x;
    t_io  vec_y;
    t_io  vec_z;
    t_io  vec_w;

    modport source (output valid, vec_x, vec_y, vec_z, vec_w, input ready);
    modport sink   (input valid, vec_x, vec_y, vec_z, vec_w, output ready);
endinterface

interface vt4_res_if;
    import vt4_pkg::*;

    logic valid;
    logic ready;
    t_io  res_x;
    t_io  res_y;
    t_io  res_z;
    t_io  res_w;
    logic saturated;

    modport source (output valid, res_x, res_y, res_z, res_w, saturated, input ready);
    modport sink   (input valid, res_x, res_y, res_z, res_w, saturated, output ready);
endinterface

interface vt4_cfg_if;
    import vt4_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/vt4_cfg_regs.sv =====
module vt4_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_en,
    input  logic [vt4_pkg::CFG_ADDR_W-1:0] i_index,
    input  logic [vt4_pkg::CFG_DATA_W-1:0] i_data,
    output vt4_pkg::t_mat                  o_mat,
    output logic                           o_row_mode
);
    import vt4_pkg::*;

    t_col r_col [DIM];
    logic r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < DIM; c++) begin
                r_col[c] <= t_col'({{(COL_W-EW){1'b0}}, ELEM_ONE}) << (c * EW);
            end
            r_mode <= 1'b0;
        end else if (i_wr_en) begin
            case (t_cfg_reg'(i_index))
                REG_COLUMN_ZERO,
                REG_COLUMN_ONE,
                REG_COLUMN_TWO,
                REG_COLUMN_THREE: begin
                    r_col[i_index[DIM_IDX_W-1:0]] <= i_data[COL_W-1:0];
                end
                REG_ROW_VECTOR_MODE: begin
                    r_mode <= i_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // element [row][col], row r at bit r*EW of its column word
    always_comb begin
        for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
                o_mat[r][c] = r_col[c][r*EW +: EW];
            end
        end
    end

    assign o_row_mode = r_mode;

endmodule

// ===== hw/rtl/vt4_pipe_ctrl.sv =====
module vt4_pipe_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_ready,
    output logic               o_in_ready,
    output vt4_pkg::t_pipe_ctl o_ctl
);
    import vt4_pkg::*;

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_vld;
    logic [NUM_STAGES:0]   free;

    // a stage may load when it is empty or its word moves on this cycle
    always_comb begin
        free[NUM_STAGES] = i_out_ready;
        for (int s = NUM_STAGES - 1; s >= 0; s--) begin
            free[s] = !r_vld[s] || free[s+1];
        end
    end

    always_comb begin
        n_vld[0] = free[0] ? i_in_valid : r_vld[0];
        for (int s = 1; s < NUM_STAGES; s++) begin
            n_vld[s] = free[s] ? r_vld[s-1] : r_vld[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready = free[0];
    assign o_ctl.en   = free[NUM_STAGES-1:0];
    assign o_ctl.vld  = r_vld;

endmodule

// ===== hw/rtl/vt4_lane.sv =====
module vt4_lane (
    input  logic               i_clk,
    input  vt4_pkg::t_pipe_ctl i_ctl,
    input  vt4_pkg::t_elem_row i_coef,
    input  vt4_pkg::t_elem_row i_vec,
    output vt4_pkg::t_io       o_res,
    output logic               o_clip
);
    import vt4_pkg::*;

    t_elem_row r_coef;
    t_elem_row r_vec;
    t_prod     r_prod [DIM];
    t_sum      r_sum;
    t_io       r_res;
    logic      r_clip;

    t_sum      sum_all;
    t_sum      shifted;
    logic      fits;
    t_elem     sat_val;

    always_comb begin
        sum_all = '0;
        for (int k = 0; k < DIM; k++) begin
            sum_all = sum_all + t_sum'(r_prod[k]);
        end
    end

    // arithmetic shift floors; value fits when all bits above the sign agree
    always_comb begin
        shifted = r_sum >>> FB;
        fits    = (&shifted[SUM_W-1:EW-1]) || !(|shifted[SUM_W-1:EW-1]);
        if (fits) begin
            sat_val = t_elem'(shifted);
        end else if (shifted[SUM_W-1]) begin
            sat_val = ELEM_MIN;
        end else begin
            sat_val = ELEM_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_coef <= i_coef;
            r_vec  <= i_vec;
        end
        if (i_ctl.en[1]) begin
            for (int k = 0; k < DIM; k++) begin
                r_prod[k] <= t_prod'(r_coef[k]) * t_prod'(r_vec[k]);
            end
        end
        if (i_ctl.en[2]) begin
            r_sum <= sum_all;
        end
        if (i_ctl.en[3]) begin
            r_res  <= t_io'(sat_val);
            r_clip <= !fits;
        end
    end

    assign o_res  = r_res;
    assign o_clip = r_clip;

endmodule

// ===== hw/rtl/vector_transform_4x4_unit.sv =====
// channel   dir   handshake        word
// i_vec     in    valid / ready    vec_x, vec_y, vec_z, vec_w (signed q8.8)
// o_res     out   valid / ready    res_x, res_y, res_z, res_w, saturated
// i_cfg     in    valid / ready    index (3 bits), data (64 bits)
//
// four register stages: operand capture, 16 multipliers, four-term adders,
// shift and clip; each result is driven from the shift and clip registers.
// one vector per cycle sustained while the output is not stalled.
// each stage loads when empty or when its word moves on, so bubbles close up
// under an output stall and nothing is dropped or repeated.
// synchronous active-low reset empties the pipe and loads the identity matrix.
module vector_transform_4x4_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vt4_vec_if.sink   i_vec,
    vt4_res_if.source o_res,
    vt4_cfg_if.sink   i_cfg
);
    import vt4_pkg::*;

    localparam t_io RES_MAX = t_io'(ELEM_MAX);
    localparam t_io RES_MIN = t_io'(ELEM_MIN);

    t_mat      mat;
    logic      row_mode;
    t_pipe_ctl ctl;
    logic      in_ready;
    t_elem_row vec;
    t_elem_row coef [DIM];
    t_io       res  [DIM];
    logic [DIM-1:0] clip;

    assign i_cfg.ready = 1'b1;

    vt4_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg.valid),
        .i_index    (i_cfg.index),
        .i_data     (i_cfg.data),
        .o_mat      (mat),
        .o_row_mode (row_mode)
    );

    vt4_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_vec.valid),
        .i_out_ready (o_res.ready),
        .o_in_ready  (in_ready),
        .o_ctl       (ctl)
    );

    assign i_vec.ready = in_ready;

    // narrow elements use the low bits of each field
    assign vec[0] = t_elem'(i_vec.vec_x);
    assign vec[1] = t_elem'(i_vec.vec_y);
    assign vec[2] = t_elem'(i_vec.vec_z);
    assign vec[3] = t_elem'(i_vec.vec_w);

    // lane i takes row i, or column i in row-vector mode
    always_comb begin
        for (int i = 0; i < DIM; i++) begin
            for (int k = 0; k < DIM; k++) begin
                coef[i][k] = row_mode ? mat[k][i] : mat[i][k];
            end
        end
    end

    for (genvar g = 0; g < DIM; g++) begin : g_lane
        vt4_lane u_lane (
            .i_clk  (i_clk),
            .i_ctl  (ctl),
            .i_coef (coef[g]),
            .i_vec  (vec),
            .o_res  (res[g]),
            .o_clip (clip[g])
        );
    end

    assign o_res.valid     = ctl.vld[NUM_STAGES-1];
    assign o_res.res_x     = res[0];
    assign o_res.res_y     = res[1];
    assign o_res.res_z     = res[2];
    assign o_res.res_w     = res[3];
    assign o_res.saturated = |clip;

    a_sat_at_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.saturated |->
            (res[0] == RES_MAX) || (res[0] == RES_MIN) ||
            (res[1] == RES_MAX) || (res[1] == RES_MIN) ||
            (res[2] == RES_MAX) || (res[2] == RES_MIN) ||
            (res[3] == RES_MAX) || (res[3] == RES_MIN))
        else $error("saturated flag set with no element at a rail");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !ctl.vld[NUM_STAGES-1] |-> i_vec.ready)
        else $error("input held off while output stage is empty");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_vec.valid && i_vec.ready |=> ctl.vld[0])
        else $error("accepted word missing from first stage");

endmodule
